// ----- hdl/pgdg_pkg.sv -----
// pgdg_pkg: widths, constants and shared types of the polar gaussian deviate generator
// no dependencies; imported by every module of the block

package pgdg_pkg;

  // uniform samples
  localparam int IN_W  = 16;
  localparam int UB    = 16;
  localparam int FB    = UB - 1;
  localparam int SW    = 2 * FB;             // radius squared, below one
  localparam int PBW   = $clog2(SW);

  // log2 recurrence
  localparam int LOG_STEPS = 24;
  localparam int MW        = 31;             // normalized mantissa, Q1.30
  localparam int LDW       = $clog2(SW + 1);
  localparam int LW        = LDW + LOG_STEPS;

  // -2 ln s = log2 term times 2 ln 2
  localparam int CW      = 31;
  localparam int T_SHIFT = 22;
  localparam int TW      = LW + CW - T_SHIFT;
  localparam logic [CW-1:0] TWO_LN2_Q30 = CW'(1488522236);

  // square roots
  localparam int RW      = (TW + 1) / 2;
  localparam int D_SHIFT = 16;
  localparam int XW      = SW + D_SHIFT;
  localparam int DW      = (XW + 1) / 2;
  localparam int NQ      = (RW > DW) ? RW : DW;
  localparam int XQ      = 2 * NQ;

  // divide and scale
  localparam int Z_SHIFT = 8;
  localparam int QW      = RW;
  localparam int NW      = UB + RW + Z_SHIFT;
  localparam int PW      = QW + 16;
  localparam int AW      = ((PW > 32) ? PW : 32) + 2;
  localparam int MU_SHIFT = 16;
  localparam int RND_SHIFT = 12;

  localparam int DEV_W = 24;

  // input queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // configuration
  localparam int CFG_IW = 2;
  localparam int CFG_W  = 16;
  localparam logic [CFG_IW-1:0] CFG_MEAN   = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_SPREAD = CFG_IW'(1);
  localparam logic [CFG_W-1:0]  SPREAD_RESET = CFG_W'(256);

  typedef struct packed {
    logic [UB-1:0] v1;
    logic [UB-1:0] v2;
    logic [SW-1:0] s;
  } pgdg_item_t;

  typedef struct packed {
    logic          valid;
    logic [UB-1:0] v1;
    logic [UB-1:0] v2;
    logic [RW-1:0] r;
    logic [DW-1:0] d;
  } pgdg_rad_t;

endpackage

// ----- hdl/pgdg_front.sv -----
// pgdg_front: queues uniform pairs with radius squared in (0, 1), drops all others
// depends on pgdg_pkg

module pgdg_front import pgdg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [31:0]     in_tdata,   // uniform_first [15:0], uniform_second [31:16]
  output pgdg_item_t      head,
  output logic            head_valid,
  input  logic            pop
);

  logic [UB-1:0]   v1, v2, a1, a2;
  logic [2*UB-1:0] s_full;
  logic            keep, push;

  pgdg_item_t      mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QAW:0]    cnt_r;

  always_comb begin
    v1 = in_tdata[UB-1:0];
    v2 = in_tdata[IN_W +: UB];
    a1 = v1[UB-1] ? (~v1 + 1'b1) : v1;
    a2 = v2[UB-1] ? (~v2 + 1'b1) : v2;
    s_full = (2*UB)'(a1) * (2*UB)'(a1) + (2*UB)'(a2) * (2*UB)'(a2);
    // zero radius and points on or outside the circle give nothing
    keep = (s_full != '0) && (s_full[2*UB-1:SW] == '0);
  end

  assign in_tready  = (cnt_r != (QAW+1)'(QDEPTH));
  assign push       = in_tvalid && in_tready && keep;
  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{v1: v1, v2: v2, s: s_full[SW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count over depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("pop from empty queue");
`endif

endmodule

// ----- hdl/pgdg_radius.sv -----
// pgdg_radius: pipelined log2, -2 ln s, sqrt(-2 ln s) and sqrt(s) for queued pairs
// depends on pgdg_pkg; fed by pgdg_front, drives pgdg_scale

module pgdg_radius import pgdg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pgdg_item_t head,
  input  logic       head_valid,
  output logic       pop,
  input  logic       en,
  output pgdg_rad_t  rad
);

  // leading one search
  logic            n_valid_r;
  logic [SW-1:0]   n_s_r;
  logic [PBW-1:0]  n_p_r, p_nxt;
  logic [UB-1:0]   n_v1_r, n_v2_r;

  logic [PBW-1:0]    shamt;
  logic [SW-1:0]     norm;
  logic [SW+MW-1:0]  ext;

  // log2 recurrence, entry 0 holds the normalized mantissa
  logic                 lg_valid_r [LOG_STEPS+1];
  logic [MW-1:0]        lg_m_r     [LOG_STEPS+1];
  logic [LOG_STEPS-1:0] lg_f_r     [LOG_STEPS+1];
  logic [PBW-1:0]       lg_p_r     [LOG_STEPS+1];
  logic [SW-1:0]        lg_s_r     [LOG_STEPS+1];
  logic [UB-1:0]        lg_v1_r    [LOG_STEPS+1];
  logic [UB-1:0]        lg_v2_r    [LOG_STEPS+1];

  logic           l_valid_r;
  logic [LW-1:0]  l_val_r, l_nxt;
  logic [SW-1:0]  l_s_r;
  logic [UB-1:0]  l_v1_r, l_v2_r;
  logic [LW+CW-1:0] t_prod;

  // both square roots side by side, one result bit per stage
  logic            sq_valid_r [NQ+1];
  logic [TW-1:0]   sq_t_r     [NQ+1];
  logic [SW-1:0]   sq_s_r     [NQ+1];
  logic [NQ+1:0]   sq_rr_r    [NQ+1];
  logic [NQ-1:0]   sq_qr_r    [NQ+1];
  logic [NQ+1:0]   sq_rd_r    [NQ+1];
  logic [NQ-1:0]   sq_qd_r    [NQ+1];
  logic [UB-1:0]   sq_v1_r    [NQ+1];
  logic [UB-1:0]   sq_v2_r    [NQ+1];

  assign pop = en && head_valid;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < SW; i++) begin
      if (head.s[i]) p_nxt = PBW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_valid_r <= 1'b0;
    end else if (en) begin
      n_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_s_r  <= head.s;
      n_p_r  <= p_nxt;
      n_v1_r <= head.v1;
      n_v2_r <= head.v2;
    end
  end

  always_comb begin
    shamt = PBW'(SW - 1) - n_p_r;
    norm  = n_s_r << shamt;
    ext   = {norm, {MW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_valid_r[0] <= 1'b0;
    end else if (en) begin
      lg_valid_r[0] <= n_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_m_r[0]  <= ext[SW+MW-1 -: MW];
      lg_f_r[0]  <= '0;
      lg_p_r[0]  <= n_p_r;
      lg_s_r[0]  <= n_s_r;
      lg_v1_r[0] <= n_v1_r;
      lg_v2_r[0] <= n_v2_r;
    end
  end

  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
    logic [2*MW-1:0] prod;
    logic [MW:0]     mq;
    logic [MW-1:0]   m_nxt;
    logic            one_b;

    always_comb begin
      prod = (2*MW)'(lg_m_r[j]) * (2*MW)'(lg_m_r[j]);
      mq   = prod[2*MW-1:MW-1];
      // square past two: halve and emit a one
      if (mq[MW]) begin
        m_nxt = mq[MW:1];
        one_b = 1'b1;
      end else begin
        m_nxt = mq[MW-1:0];
        one_b = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lg_valid_r[j+1] <= 1'b0;
      end else if (en) begin
        lg_valid_r[j+1] <= lg_valid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lg_m_r[j+1]  <= m_nxt;
        lg_f_r[j+1]  <= {lg_f_r[j][LOG_STEPS-2:0], one_b};
        lg_p_r[j+1]  <= lg_p_r[j];
        lg_s_r[j+1]  <= lg_s_r[j];
        lg_v1_r[j+1] <= lg_v1_r[j];
        lg_v2_r[j+1] <= lg_v2_r[j];
      end
    end
  end

  // -log2 s
  assign l_nxt = {LDW'(SW) - LDW'(lg_p_r[LOG_STEPS]), {LOG_STEPS{1'b0}}}
               - LW'(lg_f_r[LOG_STEPS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_valid_r <= 1'b0;
    end else if (en) begin
      l_valid_r <= lg_valid_r[LOG_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_val_r <= l_nxt;
      l_s_r   <= lg_s_r[LOG_STEPS];
      l_v1_r  <= lg_v1_r[LOG_STEPS];
      l_v2_r  <= lg_v2_r[LOG_STEPS];
    end
  end

  assign t_prod = (LW+CW)'(l_val_r) * (LW+CW)'(TWO_LN2_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r[0] <= 1'b0;
    end else if (en) begin
      sq_valid_r[0] <= l_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_t_r[0]  <= t_prod[LW+CW-1:T_SHIFT];
      sq_s_r[0]  <= l_s_r;
      sq_rr_r[0] <= '0;
      sq_qr_r[0] <= '0;
      sq_rd_r[0] <= '0;
      sq_qd_r[0] <= '0;
      sq_v1_r[0] <= l_v1_r;
      sq_v2_r[0] <= l_v2_r;
    end
  end

  for (genvar k = 0; k < NQ; k++) begin : g_sqrt
    logic [XQ-1:0]  xr, xd;
    logic [NQ+3:0]  rnr, trr, rnd, trd;
    logic [NQ+1:0]  remr_nxt, remd_nxt;
    logic [NQ-1:0]  rootr_nxt, rootd_nxt;

    always_comb begin
      xr  = XQ'(sq_t_r[k]);
      xd  = XQ'({sq_s_r[k], {D_SHIFT{1'b0}}});
      rnr = {sq_rr_r[k], xr[XQ-1-2*k -: 2]};
      trr = {2'b00, sq_qr_r[k], 2'b01};
      rnd = {sq_rd_r[k], xd[XQ-1-2*k -: 2]};
      trd = {2'b00, sq_qd_r[k], 2'b01};
      if (rnr >= trr) begin
        remr_nxt  = (NQ+2)'(rnr - trr);
        rootr_nxt = {sq_qr_r[k][NQ-2:0], 1'b1};
      end else begin
        remr_nxt  = (NQ+2)'(rnr);
        rootr_nxt = {sq_qr_r[k][NQ-2:0], 1'b0};
      end
      if (rnd >= trd) begin
        remd_nxt  = (NQ+2)'(rnd - trd);
        rootd_nxt = {sq_qd_r[k][NQ-2:0], 1'b1};
      end else begin
        remd_nxt  = (NQ+2)'(rnd);
        rootd_nxt = {sq_qd_r[k][NQ-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_valid_r[k+1] <= sq_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_t_r[k+1]  <= sq_t_r[k];
        sq_s_r[k+1]  <= sq_s_r[k];
        sq_rr_r[k+1] <= remr_nxt;
        sq_qr_r[k+1] <= rootr_nxt;
        sq_rd_r[k+1] <= remd_nxt;
        sq_qd_r[k+1] <= rootd_nxt;
        sq_v1_r[k+1] <= sq_v1_r[k];
        sq_v2_r[k+1] <= sq_v2_r[k];
      end
    end
  end

  always_comb begin
    rad.valid = sq_valid_r[NQ];
    rad.v1    = sq_v1_r[NQ];
    rad.v2    = sq_v2_r[NQ];
    rad.r     = sq_qr_r[NQ][RW-1:0];
    rad.d     = sq_qd_r[NQ][DW-1:0];
  end

endmodule

// ----- hdl/pgdg_scale.sv -----
// pgdg_scale: forms v*r/sqrt(s), applies sigma and mu, rounds, saturates, sends two words
// depends on pgdg_pkg; holds the configuration registers and the pipeline advance

module pgdg_scale import pgdg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pgdg_rad_t         rad,
  output logic              en,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DEV_W-1:0]  out_tdata,
  output logic              out_tlast
);

  logic [CFG_W-1:0] mean_r, spread_r;

  logic [UB-1:0]    mag1, mag2;
  logic [UB+RW-1:0] mr1, mr2;
  logic [NW-1:0]    n1, n2;

  logic           dv_valid_r [QW+1];
  logic [NW-1:0]  dv_n1_r    [QW+1];
  logic [NW-1:0]  dv_n2_r    [QW+1];
  logic [DW-1:0]  dv_r1_r    [QW+1];
  logic [DW-1:0]  dv_r2_r    [QW+1];
  logic [QW-1:0]  dv_q1_r    [QW+1];
  logic [QW-1:0]  dv_q2_r    [QW+1];
  logic [DW-1:0]  dv_d_r     [QW+1];
  logic           dv_g1_r    [QW+1];
  logic           dv_g2_r    [QW+1];

  logic          sg_valid_r;
  logic [PW-1:0] sg_p1_r, sg_p2_r;
  logic          sg_g1_r, sg_g2_r;

  logic             ob_valid_r, ob_last_r, take;
  logic [DEV_W-1:0] ob_a_r, ob_b_r;

  function automatic logic [DEV_W-1:0] deviate_of(input logic [PW-1:0] p, input logic neg,
                                                  input logic [CFG_W-1:0] mu);
    logic signed [AW-1:0] y, acc, q;
    logic signed [AW-1:0] half, hi, lo;
    half = AW'(1 << (RND_SHIFT - 1));
    hi   = AW'((1 << (DEV_W - 1)) - 1);
    lo   = -(AW'(1 << (DEV_W - 1)));
    y = $signed(AW'(p));
    if (neg) y = -y;
    acc = y + ($signed(AW'($signed(mu))) <<< MU_SHIFT);
    acc = acc + half;
    q = acc >>> RND_SHIFT;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[DEV_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r   <= '0;
      spread_r <= SPREAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEAN:   mean_r   <= cfg_wdata;
        CFG_SPREAD: spread_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // whole pipeline moves when the last stage is empty or the word buffer frees up
  assign take = !ob_valid_r || (ob_last_r && out_tready);
  assign en   = !sg_valid_r || take;

  always_comb begin
    mag1 = rad.v1[UB-1] ? (~rad.v1 + 1'b1) : rad.v1;
    mag2 = rad.v2[UB-1] ? (~rad.v2 + 1'b1) : rad.v2;
    mr1  = (UB+RW)'(mag1) * (UB+RW)'(rad.r);
    mr2  = (UB+RW)'(mag2) * (UB+RW)'(rad.r);
    n1   = {mr1, {Z_SHIFT{1'b0}}};
    n2   = {mr2, {Z_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (en) begin
      dv_valid_r[0] <= rad.valid;
    end
  end

  // the top part of the numerator is always below d
  always_ff @(posedge clk) begin
    if (en) begin
      dv_n1_r[0] <= n1;
      dv_n2_r[0] <= n2;
      dv_r1_r[0] <= n1[QW +: DW];
      dv_r2_r[0] <= n2[QW +: DW];
      dv_q1_r[0] <= '0;
      dv_q2_r[0] <= '0;
      dv_d_r[0]  <= rad.d;
      dv_g1_r[0] <= rad.v1[UB-1];
      dv_g2_r[0] <= rad.v2[UB-1];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0]   rn1, rn2, dd;
    logic [DW-1:0] rem1_nxt, rem2_nxt;
    logic          b1, b2;

    always_comb begin
      dd  = {1'b0, dv_d_r[k]};
      rn1 = {dv_r1_r[k], dv_n1_r[k][QW-1-k]};
      rn2 = {dv_r2_r[k], dv_n2_r[k][QW-1-k]};
      b1  = (rn1 >= dd);
      b2  = (rn2 >= dd);
      rem1_nxt = b1 ? DW'(rn1 - dd) : DW'(rn1);
      rem2_nxt = b2 ? DW'(rn2 - dd) : DW'(rn2);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_n1_r[k+1] <= dv_n1_r[k];
        dv_n2_r[k+1] <= dv_n2_r[k];
        dv_r1_r[k+1] <= rem1_nxt;
        dv_r2_r[k+1] <= rem2_nxt;
        dv_q1_r[k+1] <= {dv_q1_r[k][QW-2:0], b1};
        dv_q2_r[k+1] <= {dv_q2_r[k][QW-2:0], b2};
        dv_d_r[k+1]  <= dv_d_r[k];
        dv_g1_r[k+1] <= dv_g1_r[k];
        dv_g2_r[k+1] <= dv_g2_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_valid_r <= 1'b0;
    end else if (en) begin
      sg_valid_r <= dv_valid_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_p1_r <= PW'(dv_q1_r[QW]) * PW'(spread_r);
      sg_p2_r <= PW'(dv_q2_r[QW]) * PW'(spread_r);
      sg_g1_r <= dv_g1_r[QW];
      sg_g2_r <= dv_g2_r[QW];
    end
  end

  // word buffer: v2 deviate first, then v1 deviate with tlast
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      ob_last_r  <= 1'b0;
    end else if (en && sg_valid_r) begin
      ob_valid_r <= 1'b1;
      ob_last_r  <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      if (ob_last_r) begin
        ob_valid_r <= 1'b0;
      end else begin
        ob_last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && sg_valid_r) begin
      ob_a_r <= deviate_of(sg_p2_r, sg_g2_r, mean_r);
      ob_b_r <= deviate_of(sg_p1_r, sg_g1_r, mean_r);
    end
  end

  assign out_tvalid = ob_valid_r;
  assign out_tlast  = ob_last_r;
  assign out_tdata  = ob_last_r ? ob_b_r : ob_a_r;

`ifndef SYNTHESIS
  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && out_tlast))
    else $error("second word of pair missing");
  a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && !(en && sg_valid_r)) |=> !out_tvalid)
    else $error("word repeated after end of pair");
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> $stable(sg_p1_r) && $stable(sg_p2_r))
    else $error("last stage changed while stalled");
`endif

endmodule

// ----- hdl/polar_gaussian_deviate_generator.sv -----
// polar_gaussian_deviate_generator: top level of the polar-method normal deviate source
// depends on pgdg_pkg, pgdg_front, pgdg_radius, pgdg_scale

// Each input word carries a pair of Q1.15 uniforms; pairs with zero radius or
// on/outside the unit circle are dropped, every other pair gives two Q12.12
// deviates (the uniform_second one first, then the uniform_first one with
// tlast). Input words are taken one per clock while the four-entry queue
// has room; the queue drains into a pipeline that advances one stage per
// clock unless the output word buffer holds it (24 log2 squaring stages, a
// joint 23-stage square root, a 19-stage restoring divide). The output side
// sends two words per kept pair and loads the next pair as the last word is
// accepted; dropped pairs never enter the queue. mean_offset (index 0) and
// spread_scale (index 1) are written through the cfg port; the user must
// write them while no pair is in flight, which the block does not enforce.

module polar_gaussian_deviate_generator import pgdg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // uniform_first [15:0], uniform_second [31:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DEV_W-1:0]  out_tdata,  // deviate [23:0]
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  pgdg_item_t head;
  logic       head_valid, pop, en;
  pgdg_rad_t  rad;

  pgdg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  pgdg_radius u_radius (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .en         (en),
    .rad        (rad)
  );

  pgdg_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .rad        (rad),
    .en         (en),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
